// File: hdl/tecr_pkg.sv
// shared types and constants of the terrain color ramp
// no dependencies; used by every module of the block

package tecr_pkg;

    localparam int POS_W  = 17;                 // position 0..65536
    localparam int D_W    = 17;                 // divisor 65536 - snow_line
    localparam int Q_W    = 17;                 // saturated quotient
    localparam int P1_W   = 32;                 // |temperature| * strength
    localparam int P2_W   = P1_W + POS_W;       // times (t - snow_line)
    localparam int DROP_W = 10;                 // the extra 1024 of the divisor
    localparam int M_W    = P2_W - DROP_W;      // dividend width

    localparam logic [POS_W-1:0] POS_ONE  = 17'h10000;
    localparam logic [POS_W-1:0] Q14_ONE  = 17'h04000;

    // register indexes on the configuration port
    localparam logic REG_SNOW_LINE = 1'b0;
    localparam logic REG_STRENGTH  = 1'b1;

    localparam logic [15:0] SNOW_LINE_RST = 16'd52429;
    localparam logic [15:0] STRENGTH_RST  = 16'd4096;

    typedef struct packed {
        logic             ocean;
        logic             snow_app;
        logic             neg;
        logic [POS_W-1:0] pos;
    } side_t;

    typedef struct packed {
        logic             ocean;
        logic [POS_W-1:0] pos;
    } qent_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    localparam rgb_t OCEAN_COLORS [3] = '{
        '{8'd140, 8'd210, 8'd230},
        '{8'd40,  8'd170, 8'd210},
        '{8'd10,  8'd25,  8'd80}
    };

    localparam rgb_t LAND_COLORS [5] = '{
        '{8'd34,  8'd139, 8'd34},
        '{8'd90,  8'd180, 8'd60},
        '{8'd160, 8'd140, 8'd80},
        '{8'd100, 8'd100, 8'd100},
        '{8'd255, 8'd255, 8'd255}
    };

endpackage

// File: hdl/tecr_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating
// depends on tecr_pkg

module tecr_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [tecr_pkg::M_W-1:0]         in_m,
    input  logic [tecr_pkg::D_W-1:0]         d,
    input  tecr_pkg::side_t                  in_side,
    output logic                             out_valid,
    output logic [tecr_pkg::Q_W-1:0]         out_q,
    output logic                             out_sat,
    output tecr_pkg::side_t                  out_side
);

    localparam int STEPS = tecr_pkg::Q_W;
    localparam int HI_W  = tecr_pkg::M_W - tecr_pkg::Q_W;

    logic                         valid_reg [0:STEPS];
    logic                         sat_reg   [0:STEPS];
    tecr_pkg::side_t              side_reg  [0:STEPS];
    logic [tecr_pkg::Q_W-1:0]     q_reg     [0:STEPS];
    logic [tecr_pkg::D_W-1:0]     rem_reg   [0:STEPS-1];
    logic [tecr_pkg::Q_W-1:0]     low_reg   [0:STEPS-1];

    logic [HI_W-1:0] m_hi;

    assign m_hi = in_m[tecr_pkg::M_W-1:tecr_pkg::Q_W];

    // entry stage: quotient overflow check and initial remainder
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sat_reg[0]  <= (m_hi >= HI_W'(d));
            rem_reg[0]  <= m_hi[tecr_pkg::D_W-1:0];
            low_reg[0]  <= in_m[tecr_pkg::Q_W-1:0];
            q_reg[0]    <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic [tecr_pkg::D_W:0]   trial;
        logic                     ge;
        logic [tecr_pkg::D_W:0]   diff;

        assign trial = {rem_reg[k-1], low_reg[k-1][tecr_pkg::Q_W-1]};
        assign diff  = trial - {1'b0, d};
        // trial stays below twice the divisor, so the top bit is the borrow
        assign ge    = !diff[tecr_pkg::D_W];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sat_reg[k]  <= sat_reg[k-1];
                side_reg[k] <= side_reg[k-1];
                q_reg[k]    <= {q_reg[k-1][tecr_pkg::Q_W-2:0], ge};
            end
        end

        if (k < STEPS) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= ge ? diff[tecr_pkg::D_W-1:0] : trial[tecr_pkg::D_W-1:0];
                    low_reg[k] <= {low_reg[k-1][tecr_pkg::Q_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign out_q     = q_reg[STEPS];
    assign out_sat   = sat_reg[STEPS];
    assign out_side  = side_reg[STEPS];

endmodule

// File: hdl/tecr_front.sv
// front end: accepts samples, classifies land or ocean, applies the snow shift
// depends on tecr_pkg and tecr_div

module tecr_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [15:0]    elevation,
    input  logic signed [15:0]    temperature,
    input  logic [15:0]           snow_line,
    input  logic [15:0]           snow_temp_strength,
    input  logic                  q_full,
    output logic                  out_valid,
    output tecr_pkg::qent_t       out_entry
);

    localparam int POS_W = tecr_pkg::POS_W;
    localparam int SUM_W = POS_W + 2;

    logic                    adv;
    logic signed [POS_W-1:0] elev_ext;
    logic [POS_W-1:0]        mag;
    logic [POS_W-1:0]        clip;
    logic [POS_W-1:0]        pos0;
    logic [POS_W-1:0]        snow_ext;
    logic [15:0]             abs_temp;
    logic [tecr_pkg::D_W-1:0] d;
    tecr_pkg::side_t         side0;

    logic                    v1_reg;
    tecr_pkg::side_t         side1_reg;
    logic [15:0]             abs_temp1_reg;
    logic [POS_W-1:0]        diff1_reg;

    logic                    v2_reg;
    tecr_pkg::side_t         side2_reg;
    logic [tecr_pkg::P1_W-1:0] p1_reg;
    logic [POS_W-1:0]        diff2_reg;

    logic                    v3_reg;
    tecr_pkg::side_t         side3_reg;
    logic [tecr_pkg::P2_W-1:0] p2_reg;

    logic                    dv;
    logic [tecr_pkg::Q_W-1:0] dq;
    logic                    dsat;
    tecr_pkg::side_t         dside;

    logic [tecr_pkg::Q_W-1:0] qv;
    logic signed [SUM_W-1:0] t_s;
    logic signed [SUM_W-1:0] q_s;
    logic signed [SUM_W-1:0] sum;
    logic [POS_W-1:0]        t_new;

    logic                    out_valid_reg;
    tecr_pkg::qent_t         entry_reg;
    tecr_pkg::qent_t         entry_next;

    // whole pipe holds when the last stage cannot hand over to the queue
    assign adv     = !out_valid_reg || !q_full;
    assign s_ready = adv;

    assign snow_ext = {1'b0, snow_line};
    assign d        = tecr_pkg::POS_ONE - snow_ext;

    always_comb begin
        elev_ext = POS_W'(elevation);
        mag      = elevation[15] ? POS_W'(-elev_ext) : POS_W'(elev_ext);
        clip     = (mag > tecr_pkg::Q14_ONE) ? tecr_pkg::Q14_ONE : mag;
        pos0     = elevation[15] ? clip : POS_W'({clip, 2'b00});
        abs_temp = temperature[15] ? 16'(-temperature) : 16'(temperature);
        side0.ocean    = elevation[15];
        side0.snow_app = !elevation[15] && (pos0 > snow_ext);
        side0.neg      = temperature[15];
        side0.pos      = pos0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side1_reg     <= side0;
            abs_temp1_reg <= abs_temp;
            diff1_reg     <= pos0 - snow_ext;
            side2_reg     <= side1_reg;
            p1_reg        <= abs_temp1_reg * snow_temp_strength;
            diff2_reg     <= diff1_reg;
            side3_reg     <= side2_reg;
            p2_reg        <= p1_reg * diff2_reg;
        end
    end

    tecr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v3_reg),
        .in_m      (p2_reg[tecr_pkg::P2_W-1:tecr_pkg::DROP_W]),
        .d         (d),
        .in_side   (side3_reg),
        .out_valid (dv),
        .out_q     (dq),
        .out_sat   (dsat),
        .out_side  (dside)
    );

    // quotient is taken toward zero, so the sign only picks add or subtract
    always_comb begin
        qv    = dsat ? '1 : dq;
        t_s   = SUM_W'(dside.pos);
        q_s   = SUM_W'(qv);
        sum   = dside.neg ? (t_s + q_s) : (t_s - q_s);
        if (sum < 0) begin
            t_new = '0;
        end else if (sum > SUM_W'(tecr_pkg::POS_ONE)) begin
            t_new = tecr_pkg::POS_ONE;
        end else begin
            t_new = sum[POS_W-1:0];
        end
        entry_next.ocean = dside.ocean;
        entry_next.pos   = dside.snow_app ? t_new : dside.pos;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            entry_reg <= entry_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_entry = entry_reg;

endmodule

// File: hdl/tecr_fifo.sv
// small queue of gradient positions between the front and back ends
// depends on tecr_pkg

module tecr_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tecr_pkg::qent_t  din,
    input  logic             pop,
    output tecr_pkg::qent_t  dout,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tecr_pkg::qent_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: hdl/tecr_back.sv
// back end: samples the ocean or land gradient and holds the output color
// depends on tecr_pkg

module tecr_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  tecr_pkg::qent_t  in_entry,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output tecr_pkg::rgb_t   m_color
);

    localparam int POS_W = tecr_pkg::POS_W;

    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  u;
    logic [POS_W-1:0]  tm1;
    logic [1:0]        seg;
    logic [POS_W-1:0]  frac;
    logic              wide;
    tecr_pkg::rgb_t    col_a;
    tecr_pkg::rgb_t    col_b;
    tecr_pkg::rgb_t    color;

    logic              m_valid_reg;
    logic              m_valid_next;
    tecr_pkg::rgb_t    color_reg;

    // a + floor((b - a) * frac / span), span 2^14 or 2^16
    function automatic logic [7:0] lerp(input logic [7:0] a, input logic [7:0] b,
                                        input logic [POS_W-1:0] f, input logic w);
        logic signed [8:0]  dlt;
        logic signed [26:0] prod;
        logic signed [26:0] sh;
        logic signed [26:0] total;
        dlt   = $signed({1'b0, b}) - $signed({1'b0, a});
        prod  = dlt * $signed({1'b0, f});
        sh    = w ? (prod >>> 16) : (prod >>> 14);
        total = sh + $signed({19'd0, a});
        return total[7:0];
    endfunction

    always_comb begin
        pos   = in_entry.pos;
        u     = POS_W'({pos, 2'b00}) + pos;
        tm1   = pos - 1'b1;
        seg   = tm1[15:14];
        frac  = '0;
        wide  = 1'b0;
        col_a = tecr_pkg::OCEAN_COLORS[0];
        col_b = tecr_pkg::OCEAN_COLORS[0];
        if (in_entry.ocean) begin
            if (u == '0) begin
                col_a = tecr_pkg::OCEAN_COLORS[0];
                col_b = tecr_pkg::OCEAN_COLORS[0];
            end else if (u <= tecr_pkg::Q14_ONE) begin
                col_a = tecr_pkg::OCEAN_COLORS[0];
                col_b = tecr_pkg::OCEAN_COLORS[1];
                frac  = u;
            end else if (pos >= tecr_pkg::Q14_ONE) begin
                col_a = tecr_pkg::OCEAN_COLORS[2];
                col_b = tecr_pkg::OCEAN_COLORS[2];
            end else begin
                col_a = tecr_pkg::OCEAN_COLORS[1];
                col_b = tecr_pkg::OCEAN_COLORS[2];
                frac  = u - tecr_pkg::Q14_ONE;
                wide  = 1'b1;
            end
        end else begin
            if (pos == '0) begin
                col_a = tecr_pkg::LAND_COLORS[0];
                col_b = tecr_pkg::LAND_COLORS[0];
            end else if (pos >= tecr_pkg::POS_ONE) begin
                col_a = tecr_pkg::LAND_COLORS[4];
                col_b = tecr_pkg::LAND_COLORS[4];
            end else begin
                col_a = tecr_pkg::LAND_COLORS[seg];
                col_b = tecr_pkg::LAND_COLORS[{1'b0, seg} + 3'd1];
                frac  = pos - POS_W'({seg, 14'd0});
            end
        end
        color.r = lerp(col_a.r, col_b.r, frac, wide);
        color.g = lerp(col_a.g, col_b.g, frac, wide);
        color.b = lerp(col_a.b, col_b.b, frac, wide);
    end

    assign pop = in_valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            color_reg <= color;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_color = color_reg;

endmodule

// File: hdl/terrain_elevation_color_ramp_top.sv
// terrain elevation color ramp, top level
// depends on tecr_pkg, tecr_front, tecr_fifo and tecr_back
//
// usage:
//   s_ channel carries one cell sample per transaction; m_ channel returns one
//   rgb color per sample, in order. snow_line (byte address 0) and
//   snow_temp_strength (byte address 4) sit on the apb port; write them only
//   while no sample is in flight. paddr[1:0] are ignored.
// path: from the accepting edge to m_tvalid, a sample passes the classify
//   stage, two multiplies, one overflow check and 17 divider stages (one
//   quotient bit each), the clamp stage, the queue and the output register.
// throughput: one sample per cycle while nothing stalls; the pipelined divider
//   sets the latency, not the rate.
// reset: empties the pipeline, the queue and the output register, and loads
//   snow_line = 52429 (0.8) and snow_temp_strength = 4096 (1.0).
// stall: while m_tready is low the output holds, the queue fills, and once
//   the front end's last stage cannot hand over, s_tready drops and the whole
//   front pipeline freezes in place.

module terrain_elevation_color_ramp_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] elevation, [31:16] temperature
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] red, [15:8] green, [23:16] blue
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]     snow_line_reg;
    logic [15:0]     strength_reg;
    logic            cfg_wr;

    logic            front_valid;
    tecr_pkg::qent_t front_entry;
    logic            q_full;
    logic            q_empty;
    tecr_pkg::qent_t q_head;
    logic            q_pop;
    tecr_pkg::rgb_t  color;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snow_line_reg <= tecr_pkg::SNOW_LINE_RST;
            strength_reg  <= tecr_pkg::STRENGTH_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                tecr_pkg::REG_SNOW_LINE: snow_line_reg <= pwdata[15:0];
                tecr_pkg::REG_STRENGTH:  strength_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            tecr_pkg::REG_SNOW_LINE: prdata = {16'd0, snow_line_reg};
            tecr_pkg::REG_STRENGTH:  prdata = {16'd0, strength_reg};
            default:                 prdata = '0;
        endcase
    end

    tecr_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_tvalid),
        .s_ready            (s_tready),
        .elevation          (s_tdata[15:0]),
        .temperature        (s_tdata[31:16]),
        .snow_line          (snow_line_reg),
        .snow_temp_strength (strength_reg),
        .q_full             (q_full),
        .out_valid          (front_valid),
        .out_entry          (front_entry)
    );

    tecr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (front_valid),
        .din     (front_entry),
        .pop     (q_pop),
        .dout    (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    tecr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (!q_empty),
        .in_entry (q_head),
        .pop      (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_color  (color)
    );

    assign m_tdata = {color.b, color.g, color.r};

    // a finished position waiting on a full queue must freeze the input side
    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        front_valid && q_full |-> !s_tready)
        else $error("input accepted while front end output is blocked");

    // the output register is only loaded from a non-empty queue
    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("output loaded from an empty queue");

    // with nothing queued, a taken color leaves the output empty
    a_drain_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && q_empty |=> !m_tvalid)
        else $error("color shown with no queued position behind it");

endmodule

// File: tb/tb.sv
// self-checking testbench for the terrain elevation color ramp
// depends on tecr_pkg and terrain_elevation_color_ramp_top; predicts each color
// in fixed point and checks it against the m_ stream in order
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } shade_t;

    localparam shade_t SEA_STOPS [3] = '{
        '{8'd140, 8'd210, 8'd230},
        '{8'd40,  8'd170, 8'd210},
        '{8'd10,  8'd25,  8'd80}
    };
    localparam shade_t GROUND_STOPS [5] = '{
        '{8'd34,  8'd139, 8'd34},
        '{8'd90,  8'd180, 8'd60},
        '{8'd160, 8'd140, 8'd80},
        '{8'd100, 8'd100, 8'd100},
        '{8'd255, 8'd255, 8'd255}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] elevation, [31:16] temperature
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] red, [15:8] green, [23:16] blue
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [15:0] cfg_snow_line;
    logic [15:0] cfg_strength;
    shade_t      color_q [$];
    int          errors;
    int          rx_wait;
    int          stall_left;
    bit          tx_steady;
    bit          rx_steady;

    terrain_elevation_color_ramp_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // a + floor((b - a) * d / span)
    function automatic logic [7:0] mix_channel(int a, int b, longint d, longint span);
        longint num;
        longint q;
        num = longint'(b - a) * d;
        q = num / span;
        if (num < 0 && (num % span) != 0)
            q = q - 1;
        return 8'(a + q);
    endfunction

    function automatic shade_t mix_shade(shade_t a, shade_t b, longint d, longint span);
        shade_t c;
        c.red   = mix_channel(a.red,   b.red,   d, span);
        c.green = mix_channel(a.green, b.green, d, span);
        c.blue  = mix_channel(a.blue,  b.blue,  d, span);
        return c;
    endfunction

    function automatic shade_t predict_color(logic signed [15:0] elev,
                                             logic signed [15:0] temp);
        longint e;
        longint n;
        longint u;
        longint t;
        longint snow;
        longint shift_num;
        longint shift_den;
        longint seg;
        e = longint'(elev);
        if (e < 0) begin
            n = (-e > 16384) ? 16384 : -e;
            u = 5 * n;
            if (u <= 16384)
                return mix_shade(SEA_STOPS[0], SEA_STOPS[1], u, 16384);
            if (n >= 16384)
                return SEA_STOPS[2];
            return mix_shade(SEA_STOPS[1], SEA_STOPS[2], u - 16384, 65536);
        end
        t = (e > 16384) ? 65536 : 4 * e;
        snow = longint'(cfg_snow_line);
        if (t > snow) begin
            shift_num = longint'(temp) * longint'(cfg_strength) * (t - snow);
            shift_den = (65536 - snow) * 1024;
            t = t - shift_num / shift_den;
            if (t < 0)
                t = 0;
            if (t > 65536)
                t = 65536;
        end
        if (t <= 0)
            return GROUND_STOPS[0];
        if (t >= 65536)
            return GROUND_STOPS[4];
        seg = (t - 1) / 16384;
        return mix_shade(GROUND_STOPS[seg], GROUND_STOPS[seg + 1], t - seg * 16384, 16384);
    endfunction

    task automatic send_cell(logic signed [15:0] elev, logic signed [15:0] temp);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {temp, elev};
        do @(posedge aclk); while (!s_tready);
        color_q.insert(color_q.size(), predict_color(elev, temp));
    endtask

    // lowers valid and waits until every color has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (color_q.size() != 0)
            @(posedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    task automatic apb_write(logic reg_idx, logic [15:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (reg_idx == tecr_pkg::REG_SNOW_LINE)
            cfg_snow_line = value;
        else
            cfg_strength = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_ramp(logic [15:0] snow, logic [15:0] gain);
        wait_drained();
        apb_write(tecr_pkg::REG_SNOW_LINE, snow);
        apb_write(tecr_pkg::REG_STRENGTH, gain);
    endtask

    task automatic random_cell(output logic signed [15:0] elev,
                               output logic signed [15:0] temp);
        int near;
        case ($urandom_range(0, 7))
            0, 1: elev = 16'($urandom);
            2:    elev = -16'($urandom_range(0, 16384));
            3, 4: elev = 16'($urandom_range(0, 16384));
            default: begin
                // land just around the snow line, where the modifier acts
                near = int'(cfg_snow_line) / 4 + $urandom_range(0, 3000) - 500;
                elev = (near < 0) ? 16'sd0 : (near > 16384) ? 16'sd16384 : 16'(near);
            end
        endcase
        if ($urandom_range(0, 1) == 0)
            temp = 16'($urandom);
        else
            temp = 16'($urandom_range(0, 16384)) - 16'sd8192;
    endtask

    task automatic run_cells(int count, bit steady);
        logic signed [15:0] elev;
        logic signed [15:0] temp;
        for (int i = 0; i < count; i++) begin
            if (steady) begin
                tx_steady = 1'b1;
            end else if (i % 64 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            random_cell(elev, temp);
            send_cell(elev, temp);
        end
        tx_steady = 1'b0;
    endtask

    // stops, segment edges, clamps and the snow line, at reset settings
    task automatic test_directed();
        send_cell(16'sd0, 16'sd0);
        send_cell(-16'sd1, 16'sd0);
        send_cell(-16'sd32768, 16'sd32767);
        send_cell(16'sd32767, -16'sd32768);
        send_cell(-16'sd3276, 16'sd0);
        send_cell(-16'sd3277, 16'sd0);
        send_cell(-16'sd16383, 16'sd0);
        send_cell(-16'sd16384, 16'sd0);
        send_cell(16'sd4096, 16'sd0);
        send_cell(16'sd8192, 16'sd0);
        send_cell(16'sd12288, 16'sd0);
        send_cell(16'sd1, 16'sd0);
        send_cell(16'sd16384, 16'sd0);
        send_cell(16'sd13107, 16'sd32767);
        send_cell(16'sd13108, 16'sd32767);
        send_cell(16'sd16384, 16'sd32767);
        send_cell(16'sd16384, -16'sd32768);
        send_cell(16'sd14000, -16'sd32768);
        send_cell(16'sd15000, 16'sd16384);
        send_cell(16'sd16000, -16'sd1);
    endtask

    task automatic test_settings_sweep();
        set_ramp(16'd0, 16'd0);
        run_cells(150, 1'b0);
        set_ramp(16'd65535, 16'd65535);
        run_cells(150, 1'b0);
        set_ramp(16'd0, 16'd65535);
        run_cells(150, 1'b1);
        set_ramp(16'd65535, 16'd0);
        run_cells(150, 1'b0);
        set_ramp(16'd32768, 16'd12000);
        run_cells(150, 1'b0);
        set_ramp(16'($urandom), 16'($urandom));
        run_cells(150, 1'b0);
    endtask

    task automatic test_random();
        set_ramp(tecr_pkg::SNOW_LINE_RST, tecr_pkg::STRENGTH_RST);
        run_cells(700, 1'b0);
    endtask

    // receiver holds off long enough for the block to fill and stall s_tready
    task automatic test_backpressure();
        wait_drained();
        @(posedge aclk);
        stall_left = 250;
        run_cells(120, 1'b1);
    endtask

    task automatic test_drain_pause();
        run_cells(60, 1'b0);
        wait_drained();
        run_cells(60, 1'b0);
    endtask

    // receiver: per-transaction stall, plus the long hold-off when requested
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        shade_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (color_q.size() == 0) begin
                $display("%0t: unexpected color, expected none, actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = color_q.pop_front();
                if (m_tdata[7:0] != want.red) begin
                    $display("%0t: red expected %0d actual %0d",
                             $time, want.red, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[15:8] != want.green) begin
                    $display("%0t: green expected %0d actual %0d",
                             $time, want.green, m_tdata[15:8]);
                    errors++;
                end
                if (m_tdata[23:16] != want.blue) begin
                    $display("%0t: blue expected %0d actual %0d",
                             $time, want.blue, m_tdata[23:16]);
                    errors++;
                end
            end
            rx_wait = rx_steady ? 0 : $urandom_range(0, 8);
        end
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cfg_snow_line = tecr_pkg::SNOW_LINE_RST;
        cfg_strength  = tecr_pkg::STRENGTH_RST;
        errors        = 0;
        rx_wait       = 0;
        stall_left    = 0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_settings_sweep();
        test_random();
        test_backpressure();
        test_drain_pause();

        wait_drained();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
hdl/tecr_pkg.sv
hdl/tecr_div.sv
hdl/tecr_front.sv
hdl/tecr_fifo.sv
hdl/tecr_back.sv
hdl/terrain_elevation_color_ramp_top.sv
tb/tb.sv
